/* rtl/core/top_k_min_heap_selector_defines.svh */
// Assertion macros used by the checker file of the top-k heap selector.
`ifndef TOP_K_MIN_HEAP_SELECTOR_DEFINES_SVH
`define TOP_K_MIN_HEAP_SELECTOR_DEFINES_SVH
// Assert that a property holds on every clock edge outside reset.
`define TKH_ASSERT(lbl, clk_s, rst_n_s, prop, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (prop)) else $error(msg);
// Assert that a condition is never seen on a clock edge outside reset.
`define TKH_NEVER(lbl, clk_s, rst_n_s, cond, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) !(cond)) else $error(msg);
`endif

/* rtl/core/tkh_pkg.sv */
// Package with shared types and constants of the top-k heap selector.
package tkh_pkg;
	localparam int unsigned MaxKeep = 16;
	localparam int unsigned IdW = 20;
	localparam int unsigned ScW = 32;
	localparam int unsigned CapW = 5;
	localparam int unsigned RankW = 4;

	localparam logic [1:0] OpInsert = 2'd0;
	localparam logic [1:0] OpReport = 2'd1;
	localparam logic [1:0] OpClear  = 2'd2;

	// Commands from the controller to the datapath.
	typedef enum logic [3:0] {
		CMD_NONE   = 4'd0,
		CMD_CAPT   = 4'd1,
		CMD_APPEND = 4'd2,
		CMD_ROOT   = 4'd3,
		CMD_UPSTEP = 4'd4,
		CMD_DNSTEP = 4'd5,
		CMD_CLEAR  = 4'd6,
		CMD_RPINIT = 4'd7,
		CMD_RPSCAN = 4'd8,
		CMD_RPEMIT = 4'd9,
		CMD_EMPTY  = 4'd10
	} cmd_t;

	typedef struct packed {
		logic is_empty;
		logic can_append;
		logic do_replace;
		logic up_done;
		logic dn_done;
		logic scan_done;
		logic rep_done;
	} status_t;

	// Signed compare of scores.
	function automatic logic score_lt(input logic [ScW-1:0] a, input logic [ScW-1:0] b);
		score_lt = $signed(a) < $signed(b);
	endfunction
endpackage

/* rtl/core/tkh_ctrl.sv */
// Controller state machine of the top-k heap selector.
module tkh_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [1:0]       opcode,
	input  tkh_pkg::status_t st,
	output tkh_pkg::cmd_t    cmd,
	output logic             busy
);
	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_DEC  = 6'b000010,
		S_UP   = 6'b000100,
		S_DN   = 6'b001000,
		S_SCAN = 6'b010000,
		S_EMIT = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic [1:0] op_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q <= tkh_pkg::OpInsert;
		end else begin
			state_q <= state_d;
			if (state_q == S_IDLE && start) op_q <= opcode;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = tkh_pkg::CMD_NONE;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd = tkh_pkg::CMD_CAPT;
					state_d = S_DEC;
				end
			end
			S_DEC: begin
				state_d = S_IDLE;
				case (op_q)
					tkh_pkg::OpInsert: begin
						if (st.can_append) begin
							cmd = tkh_pkg::CMD_APPEND;
							state_d = S_UP;
						end else if (st.do_replace) begin
							cmd = tkh_pkg::CMD_ROOT;
							state_d = S_DN;
						end
					end
					tkh_pkg::OpClear: cmd = tkh_pkg::CMD_CLEAR;
					tkh_pkg::OpReport: begin
						if (st.is_empty) cmd = tkh_pkg::CMD_EMPTY;
						else begin
							cmd = tkh_pkg::CMD_RPINIT;
							state_d = S_SCAN;
						end
					end
					default: cmd = tkh_pkg::CMD_NONE;
				endcase
			end
			S_UP: begin
				cmd = tkh_pkg::CMD_UPSTEP;
				if (st.up_done) state_d = S_IDLE;
			end
			S_DN: begin
				cmd = tkh_pkg::CMD_DNSTEP;
				if (st.dn_done) state_d = S_IDLE;
			end
			S_SCAN: begin
				cmd = tkh_pkg::CMD_RPSCAN;
				if (st.scan_done) state_d = S_EMIT;
			end
			S_EMIT: begin
				cmd = tkh_pkg::CMD_RPEMIT;
				state_d = st.rep_done ? S_IDLE : S_SCAN;
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign busy = (state_q != S_IDLE);
endmodule

/* rtl/core/tkh_datapath.sv */
// Datapath of the top-k heap selector: heap registers, sift and report logic.
module tkh_datapath #(
	parameter int unsigned MAX_KEEP = tkh_pkg::MaxKeep
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  tkh_pkg::cmd_t            cmd,
	input  logic [tkh_pkg::IdW-1:0]  doc_id,
	input  logic [tkh_pkg::ScW-1:0]  score,
	input  logic                     cfg_we,
	input  logic [tkh_pkg::CapW-1:0] cfg_wdata,
	output tkh_pkg::status_t         st,
	output logic [tkh_pkg::IdW-1:0]  out_id,
	output logic [tkh_pkg::ScW-1:0]  out_score,
	output logic [tkh_pkg::RankW-1:0] rank,
	output logic                     valid_res,
	output logic                     last,
	output logic                     res_stb
);
	localparam int unsigned AW = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;
	localparam int unsigned CW = $clog2(MAX_KEEP + 1);
	localparam int unsigned PW = AW + 2;

	logic [tkh_pkg::IdW-1:0] ids_q [MAX_KEEP];
	logic [tkh_pkg::ScW-1:0] scs_q [MAX_KEEP];
	logic [MAX_KEEP-1:0] done_q;
	logic [CW-1:0] fill_q;
	logic [tkh_pkg::CapW-1:0] cap_q;
	logic [tkh_pkg::IdW-1:0] in_id_q;
	logic [tkh_pkg::ScW-1:0] in_sc_q;
	logic [AW-1:0] pos_q;
	logic [AW-1:0] scan_q;
	logic [AW-1:0] best_q;
	logic best_ok_q;
	logic [CW-1:0] emitted_q;

	logic [CW-1:0] k_eff;
	logic [CW-1:0] fill_sat;
	logic [AW-1:0] parent;
	logic [PW-1:0] lch, rch;
	logic [AW-1:0] dn_best;
	logic l_ok, r_ok;
	logic better;

	always_comb begin
		if (cap_q == '0) k_eff = CW'(1);
		else if ({27'd0, cap_q} > 32'(MAX_KEEP)) k_eff = CW'(MAX_KEEP);
		else k_eff = CW'(cap_q);
		fill_sat = fill_q;
	end

	assign parent = AW'((pos_q - AW'(1)) >> 1);
	assign lch = {1'b0, pos_q, 1'b1};
	assign rch = PW'({1'b0, pos_q, 1'b0}) + PW'(2);
	assign l_ok = {{(32-PW){1'b0}}, lch} < {{(32-CW){1'b0}}, fill_sat};
	assign r_ok = {{(32-PW){1'b0}}, rch} < {{(32-CW){1'b0}}, fill_sat};

	always_comb begin
		dn_best = pos_q;
		if (l_ok && tkh_pkg::score_lt(scs_q[lch[AW-1:0]], scs_q[pos_q]))
			dn_best = lch[AW-1:0];
		if (r_ok && tkh_pkg::score_lt(scs_q[rch[AW-1:0]], scs_q[dn_best]))
			dn_best = rch[AW-1:0];
	end

	// A candidate beats the current best when strictly greater; scanning in
	// array order keeps the earliest of equal scores first.
	assign better = !done_q[scan_q] &&
		(!best_ok_q || tkh_pkg::score_lt(scs_q[best_q], scs_q[scan_q]));

	always_comb begin
		st.is_empty = (fill_q == '0);
		st.can_append = fill_q < k_eff;
		st.do_replace = (fill_q != '0) && tkh_pkg::score_lt(scs_q[0], in_sc_q);
		st.up_done = (pos_q == '0) || !tkh_pkg::score_lt(scs_q[pos_q], scs_q[parent]);
		st.dn_done = (dn_best == pos_q);
		st.scan_done = ({{(32-AW){1'b0}}, scan_q} + 32'd1) >= {{(32-CW){1'b0}}, fill_sat};
		st.rep_done = (emitted_q + CW'(1)) == fill_sat;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			cap_q <= tkh_pkg::CapW'(16);
			res_stb <= 1'b0;
		end else begin
			res_stb <= 1'b0;
			if (cfg_we) cap_q <= cfg_wdata;
			case (cmd)
				tkh_pkg::CMD_APPEND: fill_q <= fill_q + CW'(1);
				tkh_pkg::CMD_CLEAR:  fill_q <= '0;
				tkh_pkg::CMD_EMPTY, tkh_pkg::CMD_RPEMIT: res_stb <= 1'b1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd)
			tkh_pkg::CMD_CAPT: begin
				in_id_q <= doc_id;
				in_sc_q <= score;
			end
			tkh_pkg::CMD_APPEND: begin
				ids_q[fill_q[AW-1:0]] <= in_id_q;
				scs_q[fill_q[AW-1:0]] <= in_sc_q;
				pos_q <= fill_q[AW-1:0];
			end
			tkh_pkg::CMD_ROOT: begin
				ids_q[0] <= in_id_q;
				scs_q[0] <= in_sc_q;
				pos_q <= '0;
			end
			tkh_pkg::CMD_UPSTEP: begin
				if (!st.up_done) begin
					ids_q[pos_q] <= ids_q[parent];
					scs_q[pos_q] <= scs_q[parent];
					ids_q[parent] <= ids_q[pos_q];
					scs_q[parent] <= scs_q[pos_q];
					pos_q <= parent;
				end
			end
			tkh_pkg::CMD_DNSTEP: begin
				if (!st.dn_done) begin
					ids_q[pos_q] <= ids_q[dn_best];
					scs_q[pos_q] <= scs_q[dn_best];
					ids_q[dn_best] <= ids_q[pos_q];
					scs_q[dn_best] <= scs_q[pos_q];
					pos_q <= dn_best;
				end
			end
			tkh_pkg::CMD_RPINIT: begin
				done_q <= '0;
				emitted_q <= '0;
				scan_q <= '0;
				best_ok_q <= 1'b0;
				best_q <= '0;
			end
			tkh_pkg::CMD_RPSCAN: begin
				if (better) begin
					best_q <= scan_q;
					best_ok_q <= 1'b1;
				end
				scan_q <= scan_q + AW'(1);
			end
			tkh_pkg::CMD_RPEMIT: begin
				done_q[best_q] <= 1'b1;
				out_id <= ids_q[best_q];
				out_score <= scs_q[best_q];
				rank <= tkh_pkg::RankW'(emitted_q);
				valid_res <= 1'b1;
				last <= st.rep_done;
				emitted_q <= emitted_q + CW'(1);
				scan_q <= '0;
				best_ok_q <= 1'b0;
			end
			tkh_pkg::CMD_EMPTY: begin
				out_id <= '0;
				out_score <= '0;
				rank <= '0;
				valid_res <= 1'b0;
				last <= 1'b1;
			end
			default: ;
		endcase
	end
endmodule

/* rtl/core/top_k_min_heap_selector.sv */
// Top level of the top-k heap selector: controller plus datapath.
//
// Channel   Direction  Handshake              Payload
// command   in         start high, busy low   opcode, doc_id, score
// result    out        res_valid strobe       out_id, out_score, rank, valid_res, last
// config    in         cfg_we                 cfg_wdata (capacity)
//
// An insert captures its operands, then appends the entry, replaces the root
// or drops the entry, and sifts up or down one level per step, at most about
// log2(MAX_KEEP) levels. A clear empties the heap. A report of n entries
// runs a selection scan over the heap registers for each rank.
// Reset clears the fill count and sets capacity to 16; heap contents are
// don't-care until written. Results cannot be stalled by the receiver.
module top_k_min_heap_selector #(
	parameter int unsigned MAX_KEEP = tkh_pkg::MaxKeep
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic [1:0]                opcode,
	input  logic [tkh_pkg::IdW-1:0]   doc_id,
	input  logic signed [tkh_pkg::ScW-1:0] score,
	input  logic                      cfg_we,
	input  logic [tkh_pkg::CapW-1:0]  cfg_wdata,
	output logic                      res_valid,
	output logic [tkh_pkg::IdW-1:0]   out_id,
	output logic signed [tkh_pkg::ScW-1:0] out_score,
	output logic [tkh_pkg::RankW-1:0] rank,
	output logic                      valid_res,
	output logic                      last
);
	tkh_pkg::cmd_t cmd;
	tkh_pkg::status_t st;
	logic [tkh_pkg::ScW-1:0] osc;

	// The controller sequences each command beat; the datapath holds the heap.
	tkh_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .opcode(opcode),
		.st(st), .cmd(cmd), .busy(busy)
	);

	tkh_datapath #(.MAX_KEEP(MAX_KEEP)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .doc_id(doc_id),
		.score(score), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .st(st),
		.out_id(out_id), .out_score(osc), .rank(rank),
		.valid_res(valid_res), .last(last), .res_stb(res_valid)
	);

	assign out_score = $signed(osc);
endmodule

/* rtl/core/tkh_checker.sv */
// Port-level checker for the top-k heap selector, bound to the top level.
`include "top_k_min_heap_selector_defines.svh"
module tkh_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic res_valid,
	input logic valid_res,
	input logic last,
	input logic [3:0] rank
);
	`TKH_ASSERT(a_busy_after_start, clk, arst_n, start && !busy |=> busy, "no busy after start")
	`TKH_ASSERT(a_res_while_busy, clk, arst_n, res_valid |-> $past(busy), "result outside a command")
	`TKH_NEVER(a_empty_last, clk, arst_n, res_valid && !valid_res && (!last || rank != 4'd0), "bad empty result")
	`TKH_ASSERT(a_last_idle, clk, arst_n, res_valid && last |-> !busy, "busy after last result")
endmodule

bind top_k_min_heap_selector tkh_checker u_tkh_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
	.res_valid(res_valid), .valid_res(valid_res), .last(last), .rank(rank)
);
